@@ hw/rtl/plk_pkg.sv @@
// Shared types, constants and fixed-point helpers for the planar link kinematics block.
`default_nettype none

package plk_pkg;

   // APB register port geometry
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // register indexes, at byte address 4*index
   typedef enum logic [1:0] {
      REG_OFFSET_X   = 2'd0,
      REG_OFFSET_Y   = 2'd1,
      REG_OFFSET_COS = 2'd2,
      REG_OFFSET_SIN = 2'd3
   } plk_reg_type;

   // register reset values
   localparam logic signed [31:0] OFFSET_X_RST   = 32'sd0;
   localparam logic signed [31:0] OFFSET_Y_RST   = 32'sd0;
   localparam logic signed [15:0] OFFSET_COS_RST = 16'sd16384;
   localparam logic signed [15:0] OFFSET_SIN_RST = 16'sd0;

   // Q2.14 unit and saturation bounds
   localparam logic signed [19:0] Q14_MAX = 20'sd16384;
   localparam logic signed [19:0] Q14_MIN = -20'sd16384;
   localparam logic signed [63:0] SAT_HI  = 64'sd2147483647;
   localparam logic signed [63:0] SAT_LO  = -64'sd2147483648;

   // link configuration
   typedef struct packed {
      logic signed [31:0] off_x;
      logic signed [31:0] off_y;
      logic signed [15:0] off_cos;
      logic signed [15:0] off_sin;
   } plk_cfg_type;

   // one kinematic frame, last field (pos_x) in the lowest bits
   typedef struct packed {
      logic signed [31:0] ang_acc;
      logic signed [31:0] acc_y;
      logic signed [31:0] acc_x;
      logic signed [31:0] ang_vel;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_x;
      logic signed [15:0] sin;
      logic signed [15:0] cos;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_x;
   } plk_frame_type;

   localparam int FRAME_W = $bits(plk_frame_type);

   // base rotation carried along the pipeline
   typedef struct packed {
      logic signed [15:0] c;
      logic signed [15:0] s;
   } plk_rot_type;

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] r;
      if (x > SAT_HI) begin
         r = 32'sh7FFFFFFF;
      end else if (x < SAT_LO) begin
         r = 32'sh80000000;
      end else begin
         r = signed'(x[31:0]);
      end
      return r;
   endfunction

   // Q16.16 product rescale: round to nearest, ties up
   function automatic logic signed [48:0] rnd16(input logic signed [63:0] p);
      logic signed [64:0] t;
      t = 65'(p) + 65'sd32768;
      return signed'(t[64:16]);
   endfunction

   // finish a rotated vector: combine products, round by 14, add base, saturate
   function automatic logic signed [31:0] rot_fin(input logic signed [31:0] base,
                                                  input logic signed [47:0] a,
                                                  input logic signed [47:0] b,
                                                  input logic sub);
      logic signed [48:0] sum;
      logic signed [49:0] t;
      logic signed [63:0] tot;
      sum = sub ? (49'(a) - 49'(b)) : (49'(a) + 49'(b));
      t   = 50'(sum) + 50'sd8192;
      tot = 64'(signed'(t[49:14])) + 64'(base);
      return sat32(tot);
   endfunction

   // finish a rotation product pair into a clamped Q2.14 value
   function automatic logic signed [15:0] rot_q14(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic sub);
      logic signed [32:0] sum;
      logic signed [33:0] t;
      logic signed [19:0] r;
      sum = sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
      t   = 34'(sum) + 34'sd8192;
      r   = signed'(t[33:14]);
      if (r > Q14_MAX) begin
         r = Q14_MAX;
      end else if (r < Q14_MIN) begin
         r = Q14_MIN;
      end
      return signed'(r[15:0]);
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/plk_csr.sv @@
// APB register bank holding the link offset and offset rotation.
`default_nettype none

module plk_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [plk_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [plk_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [plk_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready,
   output plk_pkg::plk_cfg_type                  cfg
);

   plk_pkg::plk_cfg_type cfg_ff;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg        = cfg_ff;

   // write on the access cycle of a write transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.off_x   <= plk_pkg::OFFSET_X_RST;
         cfg_ff.off_y   <= plk_pkg::OFFSET_Y_RST;
         cfg_ff.off_cos <= plk_pkg::OFFSET_COS_RST;
         cfg_ff.off_sin <= plk_pkg::OFFSET_SIN_RST;
      end else if (wr_en) begin
         case (csr_paddr[3:2])
            plk_pkg::REG_OFFSET_X:   cfg_ff.off_x   <= signed'(csr_pwdata);
            plk_pkg::REG_OFFSET_Y:   cfg_ff.off_y   <= signed'(csr_pwdata);
            plk_pkg::REG_OFFSET_COS: cfg_ff.off_cos <= signed'(csr_pwdata[15:0]);
            plk_pkg::REG_OFFSET_SIN: cfg_ff.off_sin <= signed'(csr_pwdata[15:0]);
            default: ;
         endcase
      end
   end

   // read back the selected register
   always_comb begin
      case (csr_paddr[3:2])
         plk_pkg::REG_OFFSET_X:   csr_prdata = cfg_ff.off_x;
         plk_pkg::REG_OFFSET_Y:   csr_prdata = cfg_ff.off_y;
         plk_pkg::REG_OFFSET_COS: csr_prdata = {16'd0, cfg_ff.off_cos};
         plk_pkg::REG_OFFSET_SIN: csr_prdata = {16'd0, cfg_ff.off_sin};
         default:                 csr_prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

@@ hw/rtl/plk_rot_mul.sv @@
// Registered product stage of a 2D rotation: the four cos/sin by vector products.
`default_nettype none

module plk_rot_mul #(
   parameter int VEC_W = 32
) (
   input  wire logic                          clock,
   input  wire logic                          en,
   input  wire logic signed [15:0]            c,
   input  wire logic signed [15:0]            s,
   input  wire logic signed [VEC_W-1:0]       ux,
   input  wire logic signed [VEC_W-1:0]       uy,
   output logic      signed [VEC_W+15:0]      cux_ff,
   output logic      signed [VEC_W+15:0]      suy_ff,
   output logic      signed [VEC_W+15:0]      sux_ff,
   output logic      signed [VEC_W+15:0]      cuy_ff
);

   logic signed [VEC_W+15:0] cux_in, suy_in, sux_in, cuy_in;

   // one multiplier per product
   assign cux_in = c * ux;
   assign suy_in = s * uy;
   assign sux_in = s * ux;
   assign cuy_in = c * uy;

   // hold while the pipeline stalls
   always_ff @(posedge clock) begin
      if (en) begin
         cux_ff <= cux_in;
         suy_ff <= suy_in;
         sux_ff <= sux_in;
         cuy_ff <= cuy_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/planar_rigid_link_kinematics.sv @@
// Top level: six-stage pipeline carrying a base frame to the end of a rigid link.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | req_tdata: base frame, 288 bits
//  rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata: end frame, 288 bits
//  csr     | in  | csr_psel/penable/pready| offset x, y, cos, sin registers
//
// One transaction enters per cycle while the output is not stalled; each result
// passes the chain of three multiply stages (position, velocity, acceleration
// rotations), each followed by a round and saturate stage.
// Reset clears all stage valid bits; registers return to identity offset.
// A stalled output holds every stage in place, the output register included.
`default_nettype none

module planar_rigid_link_kinematics (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // frame fields from bit 0 up: pos_x, pos_y, cos, sin, vel_x, vel_y, ang_vel,
   // acc_x, acc_y, ang_acc
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [plk_pkg::FRAME_W-1:0]         req_tdata,
   // frame fields from bit 0 up: pos_x, pos_y, cos, sin, vel_x, vel_y, ang_vel,
   // acc_x, acc_y, ang_acc
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [plk_pkg::FRAME_W-1:0]              rsp_tdata,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [plk_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [plk_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [plk_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                     csr_pready
);

   plk_pkg::plk_cfg_type   cfg;
   plk_pkg::plk_frame_type in_frame;
   logic                   adv;
   logic [5:0]             vld_ff;

   // stage payload
   plk_pkg::plk_frame_type fr1_ff, fr2_ff, fr3_ff, fr4_ff, fr5_ff, fr6_ff;
   plk_pkg::plk_frame_type fr2_in, fr4_in, fr6_in;
   plk_pkg::plk_rot_type   cs2_ff, cs3_ff, cs4_ff;
   logic signed [63:0]     p_wrx_ff, p_wry_ff, p_ww_ff, p_arx_ff, p_ary_ff;
   logic signed [31:0]     cx2_ff, cy2_ff, w2_ff;
   logic signed [48:0]     arx2_ff, ary2_ff, arx3_ff, ary3_ff;
   logic signed [63:0]     p_w2rx_ff, p_w2ry_ff;
   logic signed [31:0]     tx4_ff, ty4_ff;

   // rotation products
   logic signed [47:0]     pp_cx, pp_sy, pp_sx, pp_cy;
   logic signed [31:0]     rc_cx, rc_sy, rc_sx, rc_cy;
   logic signed [47:0]     vp_cx, vp_sy, vp_sx, vp_cy;
   logic signed [47:0]     ap_cx, ap_sy, ap_sx, ap_cy;

   assign in_frame   = req_tdata;
   assign adv        = !vld_ff[5] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = vld_ff[5];
   assign rsp_tdata  = fr6_ff;

   plk_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[4:0], req_tvalid};
      end
   end

   // stage 1: base rotation of the offset, angular products
   plk_rot_mul #(.VEC_W(32)) u_pos_mul (
      .clock (clock), .en (adv),
      .c (in_frame.cos), .s (in_frame.sin), .ux (cfg.off_x), .uy (cfg.off_y),
      .cux_ff (pp_cx), .suy_ff (pp_sy), .sux_ff (pp_sx), .cuy_ff (pp_cy)
   );

   plk_rot_mul #(.VEC_W(16)) u_ori_mul (
      .clock (clock), .en (adv),
      .c (in_frame.cos), .s (in_frame.sin), .ux (cfg.off_cos), .uy (cfg.off_sin),
      .cux_ff (rc_cx), .suy_ff (rc_sy), .sux_ff (rc_sx), .cuy_ff (rc_cy)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         fr1_ff   <= in_frame;
         p_wrx_ff <= in_frame.ang_vel * cfg.off_x;
         p_wry_ff <= in_frame.ang_vel * cfg.off_y;
         p_ww_ff  <= in_frame.ang_vel * in_frame.ang_vel;
         p_arx_ff <= in_frame.ang_acc * cfg.off_x;
         p_ary_ff <= in_frame.ang_acc * cfg.off_y;
      end
   end

   // stage 2: finish position and rotation, round the angular terms
   always_comb begin
      fr2_in       = fr1_ff;
      fr2_in.pos_x = plk_pkg::rot_fin(fr1_ff.pos_x, pp_cx, pp_sy, 1'b1);
      fr2_in.pos_y = plk_pkg::rot_fin(fr1_ff.pos_y, pp_sx, pp_cy, 1'b0);
      fr2_in.cos   = plk_pkg::rot_q14(rc_cx, rc_sy, 1'b1);
      fr2_in.sin   = plk_pkg::rot_q14(rc_sx, rc_cy, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fr2_ff       <= fr2_in;
         cs2_ff       <= '{c: fr1_ff.cos, s: fr1_ff.sin};
         cx2_ff       <= plk_pkg::sat32(-64'(plk_pkg::rnd16(p_wry_ff)));
         cy2_ff       <= plk_pkg::sat32(64'(plk_pkg::rnd16(p_wrx_ff)));
         w2_ff        <= plk_pkg::sat32(64'(plk_pkg::rnd16(p_ww_ff)));
         arx2_ff      <= plk_pkg::rnd16(p_arx_ff);
         ary2_ff      <= plk_pkg::rnd16(p_ary_ff);
      end
   end

   // stage 3: rotate the tangential velocity, square-rate products
   plk_rot_mul #(.VEC_W(32)) u_vel_mul (
      .clock (clock), .en (adv),
      .c (cs2_ff.c), .s (cs2_ff.s), .ux (cx2_ff), .uy (cy2_ff),
      .cux_ff (vp_cx), .suy_ff (vp_sy), .sux_ff (vp_sx), .cuy_ff (vp_cy)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         fr3_ff    <= fr2_ff;
         cs3_ff    <= cs2_ff;
         arx3_ff   <= arx2_ff;
         ary3_ff   <= ary2_ff;
         p_w2rx_ff <= w2_ff * cfg.off_x;
         p_w2ry_ff <= w2_ff * cfg.off_y;
      end
   end

   // stage 4: finish velocity, form the relative acceleration
   always_comb begin
      fr4_in       = fr3_ff;
      fr4_in.vel_x = plk_pkg::rot_fin(fr3_ff.vel_x, vp_cx, vp_sy, 1'b1);
      fr4_in.vel_y = plk_pkg::rot_fin(fr3_ff.vel_y, vp_sx, vp_cy, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fr4_ff       <= fr4_in;
         cs4_ff       <= cs3_ff;
         tx4_ff       <= plk_pkg::sat32(-64'(plk_pkg::rnd16(p_w2rx_ff)) - 64'(ary3_ff));
         ty4_ff       <= plk_pkg::sat32(-64'(plk_pkg::rnd16(p_w2ry_ff)) + 64'(arx3_ff));
      end
   end

   // stage 5: rotate the relative acceleration
   plk_rot_mul #(.VEC_W(32)) u_acc_mul (
      .clock (clock), .en (adv),
      .c (cs4_ff.c), .s (cs4_ff.s), .ux (tx4_ff), .uy (ty4_ff),
      .cux_ff (ap_cx), .suy_ff (ap_sy), .sux_ff (ap_sx), .cuy_ff (ap_cy)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         fr5_ff <= fr4_ff;
      end
   end

   // stage 6: finish acceleration into the output register
   always_comb begin
      fr6_in       = fr5_ff;
      fr6_in.acc_x = plk_pkg::rot_fin(fr5_ff.acc_x, ap_cx, ap_sy, 1'b1);
      fr6_in.acc_y = plk_pkg::rot_fin(fr5_ff.acc_y, ap_sx, ap_cy, 1'b0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fr6_ff <= fr6_in;
      end
   end

   // checks
   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (fr6_ff.cos <= 16'sd16384 && fr6_ff.cos >= -16'sd16384))
      else $error("end cosine outside unit range");

   a_sin_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (fr6_ff.sin <= 16'sd16384 && fr6_ff.sin >= -16'sd16384))
      else $error("end sine outside unit range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("pipeline not empty after reset");

   a_out_from_stage5: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(vld_ff[4]))
      else $error("result appeared without an item in stage five");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the planar rigid-link kinematics pipeline.
module testbench;
   import plk_pkg::*;

   localparam int PHASES          = 7;
   localparam int ITEMS_PER_PHASE = 257;
   localparam int TAIL_CYCLES     = 12;

   // one row of the directed table; want is used only where lit is set
   typedef struct {
      bit            set_cfg;
      plk_cfg_type   cfg;
      plk_frame_type frame;
      bit            lit;
      plk_frame_type want;
   } directed_row_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [FRAME_W-1:0]      req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b1;
   logic [FRAME_W-1:0]      rsp_tdata;
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   plk_cfg_type             link_cfg;
   plk_frame_type           pending_ends[$];
   directed_row_type        directed_rows[$];
   int                      mismatch_count = 0;
   bit                      idling_on = 1'b1;

   planar_rigid_link_kinematics i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // round to nearest, ties toward +infinity
   function automatic longint round_shift(input longint x, input int n);
      return (x + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint sat32(input longint x);
      if (x > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (x < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return x;
   endfunction

   function automatic longint clamp_q14(input longint x);
      if (x > 64'sd16384) begin
         return 64'sd16384;
      end
      if (x < -64'sd16384) begin
         return -64'sd16384;
      end
      return x;
   endfunction

   function automatic longint mul_q16(input longint a, input longint b);
      return round_shift(a * b, 16);
   endfunction

   // base plus the vector u rotated by (c, s), saturated
   function automatic logic [31:0] rotate_add(input logic signed [31:0] base,
                                              input longint c, input longint s,
                                              input longint ux, input longint uy,
                                              input bit ycomp);
      longint sum;
      sum = ycomp ? (s * ux + c * uy) : (c * ux - s * uy);
      return 32'(sat32(longint'(base) + round_shift(sum, 14)));
   endfunction

   // end-of-link frame for a base frame under the current link offsets
   function automatic plk_frame_type link_end_frame(input plk_frame_type b);
      plk_frame_type e;
      longint c, s, rx, ry, oc, os, w, al, cx, cy, w2, tx, ty;
      c  = longint'(b.cos);
      s  = longint'(b.sin);
      rx = longint'(link_cfg.off_x);
      ry = longint'(link_cfg.off_y);
      oc = longint'(link_cfg.off_cos);
      os = longint'(link_cfg.off_sin);
      w  = longint'(b.ang_vel);
      al = longint'(b.ang_acc);
      e  = b;
      e.pos_x = rotate_add(b.pos_x, c, s, rx, ry, 1'b0);
      e.pos_y = rotate_add(b.pos_y, c, s, rx, ry, 1'b1);
      e.cos   = 16'(clamp_q14(round_shift(c * oc - s * os, 14)));
      e.sin   = 16'(clamp_q14(round_shift(s * oc + c * os, 14)));
      // tangential term w x r
      cx = sat32(-mul_q16(w, ry));
      cy = sat32(mul_q16(w, rx));
      e.vel_x = rotate_add(b.vel_x, c, s, cx, cy, 1'b0);
      e.vel_y = rotate_add(b.vel_y, c, s, cx, cy, 1'b1);
      // centripetal plus angular acceleration term
      w2 = sat32(mul_q16(w, w));
      tx = sat32(-mul_q16(w2, rx) - mul_q16(al, ry));
      ty = sat32(-mul_q16(w2, ry) + mul_q16(al, rx));
      e.acc_x = rotate_add(b.acc_x, c, s, tx, ty, 1'b0);
      e.acc_y = rotate_add(b.acc_y, c, s, tx, ty, 1'b1);
      return e;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic plk_frame_type make_frame(input logic [31:0] px, input logic [31:0] py,
                                                input logic [15:0] c, input logic [15:0] s,
                                                input logic [31:0] vx, input logic [31:0] vy,
                                                input logic [31:0] w,
                                                input logic [31:0] ax, input logic [31:0] ay,
                                                input logic [31:0] al);
      plk_frame_type f;
      f.pos_x = px;  f.pos_y = py;  f.cos = c;  f.sin = s;
      f.vel_x = vx;  f.vel_y = vy;  f.ang_vel = w;
      f.acc_x = ax;  f.acc_y = ay;  f.ang_acc = al;
      return f;
   endfunction

   function automatic plk_cfg_type make_cfg(input logic [31:0] x, input logic [31:0] y,
                                            input logic [15:0] c, input logic [15:0] s);
      plk_cfg_type g;
      g.off_x = x;  g.off_y = y;  g.off_cos = c;  g.off_sin = s;
      return g;
   endfunction

   function automatic logic [31:0] rand_q16();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2: ;
         3: begin
            case ($urandom_range(0, 4))
               0: v = 32'h7FFFFFFF;
               1: v = 32'h80000000;
               2: v = 32'h00000000;
               3: v = 32'h00000001;
               default: v = 32'hFFFFFFFF;
            endcase
         end
         4, 5, 6: v = 32'($signed(v[19:0]));
         default: v = 32'($signed(v[25:0]));
      endcase
      return v;
   endfunction

   // rotation component; raw_ok allows any 16-bit pattern
   function automatic logic [15:0] rand_q14(input bit raw_ok);
      logic [15:0] v;
      v = 16'(int'($urandom_range(0, 32768)) - 16384);
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 2))
               0: v = 16'sd16384;
               1: v = -16'sd16384;
               default: v = 16'h0000;
            endcase
         end
         1, 2: if (raw_ok) v = 16'($urandom);
         default: ;
      endcase
      return v;
   endfunction

   function automatic plk_frame_type random_frame();
      return make_frame(rand_q16(), rand_q16(), rand_q14(1'b1), rand_q14(1'b1),
                        rand_q16(), rand_q16(), rand_q16(),
                        rand_q16(), rand_q16(), rand_q16());
   endfunction

   function automatic plk_cfg_type random_link(input int phase);
      plk_cfg_type g;
      case (phase)
         0: g = make_cfg(OFFSET_X_RST, OFFSET_Y_RST, OFFSET_COS_RST, OFFSET_SIN_RST);
         1: g = make_cfg(32'h7FFFFFFF, 32'h7FFFFFFF, 16'sd16384, 16'sd16384);
         2: g = make_cfg(32'h80000000, 32'h80000000, -16'sd16384, -16'sd16384);
         3: g = make_cfg($urandom, $urandom, rand_q14(1'b1), rand_q14(1'b1));
         4, 6: g = make_cfg(32'($signed(20'($urandom))), 32'($signed(20'($urandom))),
                            rand_q14(1'b0), rand_q14(1'b0));
         default: g = make_cfg($urandom, $urandom, rand_q14(1'b0), rand_q14(1'b0));
      endcase
      return g;
   endfunction

   task automatic add_row(input bit set_cfg, input plk_cfg_type cfg,
                          input plk_frame_type frame, input bit lit,
                          input plk_frame_type want);
      directed_row_type r;
      r.set_cfg = set_cfg;
      r.cfg     = cfg;
      r.frame   = frame;
      r.lit     = lit;
      r.want    = want;
      directed_rows.push_back(r);
   endtask

   // ---------------------------------------------------------------- bus drivers

   task automatic csr_write(input plk_reg_type idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_link(input plk_cfg_type g);
      csr_write(REG_OFFSET_X, g.off_x);
      csr_write(REG_OFFSET_Y, g.off_y);
      csr_write(REG_OFFSET_COS, 32'(g.off_cos));
      csr_write(REG_OFFSET_SIN, 32'(g.off_sin));
      link_cfg = g;
   endtask

   // drop valid, wait for every pending result, then let the pipeline empty
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_ends.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // present one base frame, hold until accepted, then queue its result
   task automatic send_frame(input plk_frame_type f, input plk_frame_type want);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_ends.push_back(want);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_frame(input plk_frame_type want, input plk_frame_type got);
      compare_field("end_pos_x", want.pos_x, got.pos_x);
      compare_field("end_pos_y", want.pos_y, got.pos_y);
      compare_field("end_cos", 32'(want.cos), 32'(got.cos));
      compare_field("end_sin", 32'(want.sin), 32'(got.sin));
      compare_field("end_vel_x", want.vel_x, got.vel_x);
      compare_field("end_vel_y", want.vel_y, got.vel_y);
      compare_field("end_ang_vel", want.ang_vel, got.ang_vel);
      compare_field("end_acc_x", want.acc_x, got.acc_x);
      compare_field("end_acc_y", want.acc_y, got.acc_y);
      compare_field("end_ang_acc", want.ang_acc, got.ang_acc);
   endtask

   // match each result transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_ends.size() == 0) begin
            $error("unexpected result transaction: %h", rsp_tdata);
            mismatch_count++;
         end else begin
            check_frame(pending_ends.pop_front(), plk_frame_type'(rsp_tdata));
         end
      end
   end

   // stall the result side in random bursts
   initial begin
      forever begin
         repeat ($urandom_range(1, 16)) @(posedge clock);
         if (idling_on && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      plk_cfg_type      cfg_a, cfg_b, cfg_c, cfg_d, none;
      plk_frame_type    f, zero;
      directed_row_type row;

      link_cfg = make_cfg(OFFSET_X_RST, OFFSET_Y_RST, OFFSET_COS_RST, OFFSET_SIN_RST);
      none  = link_cfg;
      zero  = '0;
      cfg_a = make_cfg(32'h7FFFFFFF, 32'h80000000, 16'sd11585, 16'sd11585);
      cfg_b = make_cfg(32'h00002000, 32'h00008000, 16'sd8192, -16'sd8192);
      cfg_c = make_cfg(32'h80000000, 32'h80000000, -16'sd16384, -16'sd16384);
      cfg_d = make_cfg(32'h7FFFFFFF, 32'h7FFFFFFF, 16'sd16384, 16'sd16384);

      // identity offsets after reset: the frame passes, rotation clamped
      f = make_frame(0, 0, 16'sd16384, 16'h0000, 0, 0, 0, 0, 0, 0);
      add_row(1'b0, none, f, 1'b1, f);
      f = make_frame(32'h7FFFFFFF, 32'h7FFFFFFF, 16'sd16384, 16'h0000, 32'h7FFFFFFF,
                     32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
      add_row(1'b0, none, f, 1'b1, f);
      f = make_frame(32'h80000000, 32'h80000000, -16'sd16384, 16'h0000, 32'h80000000,
                     32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
      add_row(1'b0, none, f, 1'b1, f);
      f = make_frame(32'h12345678, 32'h00018000, 16'h0000, 16'sd16384, 32'h00000001,
                     32'hFFFF0000, 32'h00010000, 32'h7FFF0000, 32'h80010000, 32'h00000010);
      add_row(1'b0, none, f, 1'b1, f);
      f = make_frame(32'hFFFFFFFF, 32'hFFFFFFFE, 16'h0000, -16'sd16384, 32'hFFFFFFFF,
                     32'h00000000, 32'hFFFFFFFF, 32'h0000FFFF, 32'hFFFF0001, 32'hFFFFFFFF);
      add_row(1'b0, none, f, 1'b1, f);
      f = make_frame(32'hAAAAAAAA, 32'h55555555, 16'h7FFF, 16'h8000, 32'hAAAAAAAA, 32'h55555555,
                     32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555);
      row.want = f;
      row.want.cos = 16'sd16384;
      row.want.sin = -16'sd16384;
      add_row(1'b0, none, f, 1'b1, row.want);
      f = make_frame(32'h55555555, 32'hAAAAAAAA, 16'h8000, 16'h7FFF, 32'h55555555, 32'hAAAAAAAA,
                     32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
      row.want = f;
      row.want.cos = -16'sd16384;
      row.want.sin = 16'sd16384;
      add_row(1'b0, none, f, 1'b1, row.want);
      f = make_frame(32'h00000003, 32'hFFFFFFFD, 16'h0001, 16'hFFFF, 32'h00000002, 32'h00000005,
                     32'h00000007, 32'hFFFFFFF0, 32'h00000100, 32'h00000009);
      add_row(1'b0, none, f, 1'b1, f);

      // full-scale offsets, to exercise saturation
      add_row(1'b1, cfg_a, make_frame(0, 0, 16'sd16384, 16'h0000, 0, 0, 0, 0, 0, 0),
              1'b0, zero);
      add_row(1'b0, cfg_a, make_frame(32'h7FFFFFFF, 32'h7FFFFFFF, 16'sd16384, 16'sd16384,
                                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                      32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0, zero);
      add_row(1'b0, cfg_a, make_frame(32'h80000000, 32'h80000000, -16'sd16384, -16'sd16384,
                                      32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                      32'h80000000, 32'h80000000), 1'b0, zero);
      add_row(1'b0, cfg_a, make_frame(0, 0, 16'h0000, 16'sd16384, 0, 0, 32'h7FFFFFFF, 0, 0,
                                      32'h80000000), 1'b0, zero);
      add_row(1'b0, cfg_a, make_frame(32'h00010000, 32'hFFFF0000, 16'h7FFF, 16'h7FFF,
                                      32'h01000000, 32'hFF000000, 32'h00020000, 32'h00000000,
                                      32'h00000000, 32'h00030000), 1'b0, zero);

      // small offsets where the rescaling hits exact half steps
      add_row(1'b1, cfg_b, make_frame(0, 0, 16'h0001, 16'h0000, 0, 0, 32'h00000001, 0, 0,
                                      32'h00000001), 1'b0, zero);
      add_row(1'b0, cfg_b, make_frame(0, 0, 16'hFFFF, 16'h0000, 0, 0, 32'hFFFFFFFF, 0, 0,
                                      32'hFFFFFFFF), 1'b0, zero);
      add_row(1'b0, cfg_b, make_frame(32'h00000005, 0, 16'h0001, 16'h0001, 0, 0,
                                      32'h00000002, 0, 0, 0), 1'b0, zero);
      add_row(1'b0, cfg_b, make_frame(0, 32'hFFFFFFFB, 16'h0000, 16'hFFFF, 0, 0, 32'h00010000,
                                      0, 0, 32'h00010000), 1'b0, zero);

      // most negative offsets and rotation
      add_row(1'b1, cfg_c, make_frame(32'h7FFFFFFF, 32'h7FFFFFFF, 16'sd16384, 16'h0000,
                                      32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                      32'h7FFFFFFF, 32'h7FFFFFFF), 1'b0, zero);
      add_row(1'b0, cfg_c, make_frame(32'h80000000, 32'h80000000, -16'sd16384, 16'sd16384,
                                      32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                                      32'h80000000, 32'h80000000), 1'b0, zero);
      add_row(1'b0, cfg_c, make_frame(0, 0, 16'sd16384, 16'sd16384, 0, 0, 32'h80000000, 0, 0,
                                      32'h80000000), 1'b0, zero);

      // most positive offsets and rotation
      add_row(1'b1, cfg_d, make_frame(32'h80000000, 32'h80000000, -16'sd16384, -16'sd16384,
                                      32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                                      32'h80000000, 32'h7FFFFFFF), 1'b0, zero);
      add_row(1'b0, cfg_d, make_frame(0, 0, 16'sd16384, 16'h0000, 0, 0, 0, 0, 0, 0),
              1'b0, zero);

      // hold reset, then release
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the directed table
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.set_cfg) begin
            settle();
            program_link(row.cfg);
         end
         send_frame(row.frame, row.lit ? row.want : link_end_frame(row.frame));
      end

      // random frames over several link settings, no idling in the last one
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         program_link(random_link(ph));
         idling_on = (ph != PHASES - 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            f = random_frame();
            send_frame(f, link_end_frame(f));
         end
      end
      settle();

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/plk_pkg.sv
hw/rtl/plk_csr.sv
hw/rtl/plk_rot_mul.sv
hw/rtl/planar_rigid_link_kinematics.sv
test/testbench.sv
